FILE: design/sidt_pkg.sv
// shared types and constants for the signed integer to decimal text block
package sidt_pkg;

    localparam int unsigned DIGIT_W = 4;

    localparam logic [6:0] CHAR_ZERO  = 7'd48;
    localparam logic [6:0] CHAR_MINUS = 7'd45;
    localparam logic [3:0] DIGIT_FIVE  = 4'd5;
    localparam logic [3:0] DIGIT_THREE = 4'd3;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CONV,
        ST_STRIP,
        ST_SIGN,
        ST_DIGIT
    } t_state;

    typedef struct packed {
        logic load;
        logic step;
        logic shift_digit;
        logic sel_minus;
    } t_cmd;

    typedef struct packed {
        logic neg;
        logic conv_done;
        logic top_zero;
        logic one_left;
    } t_status;

endpackage

FILE: design/signed_int_to_decimal_text.sv
// top level: signed integer to decimal ascii text converter
//
//  channel  direction  handshake                  payload
//  in       input      i_in_valid / o_in_ready    i_value
//  out      output     o_out_valid / i_out_ready  o_char_code, o_last
//
// one value at a time: a load, VALUE_BITS double-dabble steps, then one strip
// step per leading zero digit dropped plus one to leave the strip, then one
// character per cycle when the output side is ready (up to 11 at 32 bits).
// the shift-and-add-3 step runs over the bcd register once per bit of the value.
// reset is synchronous, active low, and returns the controller to idle.
// a stalled output holds the current character; no new value is taken until
// the final character of the current one has been taken.
module signed_int_to_decimal_text #(
    parameter int VALUE_BITS = 32
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_in_valid,
    output logic                         o_in_ready,
    input  logic signed [VALUE_BITS-1:0] i_value,
    output logic                         o_out_valid,
    input  logic                         i_out_ready,
    output logic [6:0]                   o_char_code,
    output logic                         o_last
);

    sidt_pkg::t_cmd    w_cmd;
    sidt_pkg::t_status w_status;

    sidt_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .i_status    (w_status),
        .o_cmd       (w_cmd)
    );

    sidt_datapath #(
        .VALUE_BITS (VALUE_BITS)
    ) u_datapath (
        .i_clk       (i_clk),
        .i_value     (i_value),
        .i_cmd       (w_cmd),
        .o_status    (w_status),
        .o_char_code (o_char_code),
        .o_last      (o_last)
    );

endmodule

FILE: design/sidt_datapath.sv
// magnitude register, double-dabble bcd register and character output logic
module sidt_datapath #(
    parameter int VALUE_BITS = 32
) (
    input  logic                         i_clk,
    input  logic signed [VALUE_BITS-1:0] i_value,
    input  sidt_pkg::t_cmd               i_cmd,
    output sidt_pkg::t_status            o_status,
    output logic [6:0]                   o_char_code,
    output logic                         o_last
);

    localparam int NDIG   = (VALUE_BITS * 3) / 10 + 1;
    localparam int BCD_W  = NDIG * sidt_pkg::DIGIT_W;
    localparam int CNT_W  = $clog2(VALUE_BITS);
    localparam int LEFT_W = $clog2(NDIG + 1);

    logic [VALUE_BITS-1:0] r_mag, n_mag;
    logic [BCD_W-1:0]      r_bcd, n_bcd;
    logic [CNT_W-1:0]      r_cnt, n_cnt;
    logic [LEFT_W-1:0]     r_left, n_left;
    logic                  r_neg, n_neg;

    logic [VALUE_BITS-1:0] w_raw;
    logic [VALUE_BITS-1:0] w_abs;
    logic [BCD_W-1:0]      w_adj;
    logic [3:0]            w_top;

    assign w_raw = i_value;
    assign w_abs = w_raw[VALUE_BITS-1] ? (~w_raw + 1'b1) : w_raw;
    assign w_top = r_bcd[BCD_W-1 -: sidt_pkg::DIGIT_W];

    // add three to every digit of five or more before the shift
    always_comb begin
        w_adj = r_bcd;
        for (int d = 0; d < NDIG; d++) begin
            if (r_bcd[d*sidt_pkg::DIGIT_W +: sidt_pkg::DIGIT_W] >= sidt_pkg::DIGIT_FIVE) begin
                w_adj[d*sidt_pkg::DIGIT_W +: sidt_pkg::DIGIT_W] =
                    r_bcd[d*sidt_pkg::DIGIT_W +: sidt_pkg::DIGIT_W] + sidt_pkg::DIGIT_THREE;
            end
        end
    end

    always_comb begin
        n_mag  = r_mag;
        n_bcd  = r_bcd;
        n_cnt  = r_cnt;
        n_left = r_left;
        n_neg  = r_neg;
        if (i_cmd.load) begin
            n_mag  = w_abs;
            n_bcd  = '0;
            n_cnt  = '0;
            n_left = LEFT_W'(NDIG);
            n_neg  = w_raw[VALUE_BITS-1];
        end else if (i_cmd.step) begin
            n_bcd = {w_adj[BCD_W-2:0], r_mag[VALUE_BITS-1]};
            n_mag = {r_mag[VALUE_BITS-2:0], 1'b0};
            n_cnt = r_cnt + 1'b1;
        end else if (i_cmd.shift_digit) begin
            n_bcd  = {r_bcd[BCD_W-sidt_pkg::DIGIT_W-1:0], {sidt_pkg::DIGIT_W{1'b0}}};
            n_left = r_left - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        r_mag  <= n_mag;
        r_bcd  <= n_bcd;
        r_cnt  <= n_cnt;
        r_left <= n_left;
        r_neg  <= n_neg;
    end

    assign o_status.neg       = r_neg;
    assign o_status.conv_done = (r_cnt == CNT_W'(VALUE_BITS - 1));
    assign o_status.top_zero  = (w_top == '0);
    assign o_status.one_left  = (r_left == LEFT_W'(1));

    assign o_char_code = i_cmd.sel_minus ? sidt_pkg::CHAR_MINUS
                                         : (sidt_pkg::CHAR_ZERO + {3'b000, w_top});
    assign o_last      = !i_cmd.sel_minus && o_status.one_left;

endmodule

FILE: design/sidt_ctrl.sv
// controller state machine: load, convert, strip leading zeros, emit characters
module sidt_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    output logic              o_out_valid,
    input  logic              i_out_ready,
    input  sidt_pkg::t_status i_status,
    output sidt_pkg::t_cmd    o_cmd
);

    sidt_pkg::t_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= sidt_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state     = r_state;
        o_in_ready  = 1'b0;
        o_out_valid = 1'b0;
        o_cmd       = '0;
        unique case (r_state)
            sidt_pkg::ST_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = sidt_pkg::ST_CONV;
                end
            end
            sidt_pkg::ST_CONV: begin
                o_cmd.step = 1'b1;
                if (i_status.conv_done) begin
                    n_state = sidt_pkg::ST_STRIP;
                end
            end
            sidt_pkg::ST_STRIP: begin
                // drop leading zero digits, always keep the last one
                if (i_status.top_zero && !i_status.one_left) begin
                    o_cmd.shift_digit = 1'b1;
                end else if (i_status.neg) begin
                    n_state = sidt_pkg::ST_SIGN;
                end else begin
                    n_state = sidt_pkg::ST_DIGIT;
                end
            end
            sidt_pkg::ST_SIGN: begin
                o_out_valid     = 1'b1;
                o_cmd.sel_minus = 1'b1;
                if (i_out_ready) begin
                    n_state = sidt_pkg::ST_DIGIT;
                end
            end
            sidt_pkg::ST_DIGIT: begin
                o_out_valid = 1'b1;
                if (i_out_ready) begin
                    o_cmd.shift_digit = 1'b1;
                    if (i_status.one_left) begin
                        n_state = sidt_pkg::ST_IDLE;
                    end
                end
            end
            default: begin
                n_state = sidt_pkg::ST_IDLE;
            end
        endcase
    end

    a_load_starts_conv: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |=> (r_state == sidt_pkg::ST_CONV))
        else $error("accepted transaction did not start conversion");

    a_conv_to_strip: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == sidt_pkg::ST_CONV && i_status.conv_done) |=>
            (r_state == sidt_pkg::ST_STRIP))
        else $error("conversion did not end after its last step");

    a_sign_only_negative: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == sidt_pkg::ST_SIGN) |-> i_status.neg)
        else $error("minus sign emitted for non-negative value");

    a_no_overlap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(o_in_ready && o_out_valid))
        else $error("input accepted while characters still pending");

    a_last_returns_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == sidt_pkg::ST_DIGIT && i_out_ready && i_status.one_left) |=>
            (r_state == sidt_pkg::ST_IDLE))
        else $error("block did not return to idle after final character");

endmodule

FILE: bench/tb_signed_int_to_decimal_text.sv
// testbench for the signed integer to decimal ascii text converter
`timescale 1ns / 100ps

module tb_signed_int_to_decimal_text;

    localparam int VALUE_BITS   = 32;
    localparam int DIRECTED_N   = 20;
    localparam int RANDOM_PER_PHASE = 117;
    localparam int DRAIN_LIMIT  = 20000;
    localparam int PRINT_LIMIT  = 100;

    typedef logic signed [VALUE_BITS-1:0] t_value;

    typedef struct packed {
        logic [6:0] code;
        logic       last;
    } t_text_char;

    logic         i_clk;
    logic         i_rst_n;
    logic         i_in_valid;
    logic         o_in_ready;
    t_value       i_value;
    logic         o_out_valid;
    logic         i_out_ready;
    logic [6:0]   o_char_code;
    logic         o_last;

    t_text_char   expected_chars[$];
    int           mismatch_count = 0;
    int           send_idle_pct = 0;
    int           out_stall_pct = 0;

    // directed rows: an empty string means the predictor supplies the text
    t_value directed_value [DIRECTED_N] = '{
        0, 1, -1, 9, -9, 10, -10, 99, 100, 7,
        32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0001, 999999999, 1000000000,
        -1000000000, 32'h5555_5555, 32'hAAAA_AAAA, -12345, 1234567890
    };
    string directed_text [DIRECTED_N] = '{
        "0", "1", "-1", "9", "-9", "10", "-10", "99", "100", "",
        "2147483647", "-2147483648", "-2147483647", "", "",
        "", "", "", "", ""
    };

    signed_int_to_decimal_text #(
        .VALUE_BITS(VALUE_BITS)
    ) dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_value    (i_value),
        .o_out_valid(o_out_valid),
        .i_out_ready(i_out_ready),
        .o_char_code(o_char_code),
        .o_last     (o_last)
    );

    initial i_clk = 1'b0;
    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    task automatic report_mismatch(input string msg);
        if (mismatch_count < PRINT_LIMIT) begin
            $display("[%0t] MISMATCH: %s", $realtime, msg);
        end
        mismatch_count++;
    endtask

    // decimal text of one value, most significant character first
    function automatic void predict_text(input t_value number);
        logic [VALUE_BITS-1:0] mag;
        logic [3:0]            digits[$];
        t_text_char            ch;
        mag = number;
        if (number[VALUE_BITS-1]) begin
            mag = ~mag + 1'b1;
        end
        do begin
            digits.push_front(4'(mag % 10));
            mag = mag / 10;
        end while (mag != 0);
        if (number[VALUE_BITS-1]) begin
            ch.code = sidt_pkg::CHAR_MINUS;
            ch.last = 1'b0;
            expected_chars.push_back(ch);
        end
        foreach (digits[i]) begin
            ch.code = sidt_pkg::CHAR_ZERO + 7'(digits[i]);
            ch.last = (i == digits.size() - 1);
            expected_chars.push_back(ch);
        end
    endfunction

    function automatic void expect_typed_text(input string text);
        t_text_char ch;
        for (int i = 0; i < text.len(); i++) begin
            ch.code = 7'(text[i]);
            ch.last = (i == text.len() - 1);
            expected_chars.push_back(ch);
        end
    endfunction

    // uniform random values, values spread over every digit count, small values, near powers of ten and extremes
    function automatic t_value random_value();
        int unsigned kind;
        longint      lo;
        longint      hi;
        longint      mag;
        kind = $urandom_range(9);
        case (kind)
            4, 5, 6: begin
                lo = 1;
                repeat ($urandom_range(10, 1) - 1) lo = lo * 10;
                hi = lo * 10 - 1;
                if (hi > 64'sd2147483647) begin
                    hi = 64'sd2147483647;
                end
                mag = longint'($urandom_range(32'(hi), 32'(lo)));
                if ($urandom_range(1) == 1) begin
                    mag = -mag;
                end
                return t_value'(mag);
            end
            7: begin
                mag = 1;
                repeat ($urandom_range(9)) mag = mag * 10;
                mag = mag + longint'($urandom_range(2)) - 1;
                if ($urandom_range(1) == 1) begin
                    mag = -mag;
                end
                return t_value'(mag);
            end
            8: begin
                return t_value'(longint'($urandom_range(20)) - 10);
            end
            9: begin
                if ($urandom_range(1) == 1) begin
                    return t_value'(32'h7FFF_FFFF - $urandom_range(3));
                end
                return t_value'(32'h8000_0000 + $urandom_range(3));
            end
            default: begin
                return t_value'($urandom);
            end
        endcase
    endfunction

    // called at a falling edge, returns at the falling edge after the transaction
    task automatic send_value(input t_value number, input string text);
        while ($urandom_range(99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_value    <= number;
        do @(posedge i_clk); while (o_in_ready !== 1'b1);
        if (text.len() > 0) begin
            expect_typed_text(text);
        end else begin
            predict_text(number);
        end
        @(negedge i_clk);
    endtask

    // hold the input side off until the block has emitted everything owed
    task automatic drain_text(input int limit);
        int waited;
        waited = 0;
        i_in_valid <= 1'b0;
        do begin
            @(negedge i_clk);
            waited++;
        end while (expected_chars.size() != 0 && waited < limit);
    endtask

    always @(negedge i_clk) begin
        i_out_ready <= ($urandom_range(99) >= out_stall_pct);
    end

    always @(posedge i_clk) begin
        t_text_char want;
        if (i_rst_n) begin
            if (o_out_valid !== 1'b0 && o_out_valid !== 1'b1) begin
                report_mismatch("o_out_valid is unknown");
            end else if (o_out_valid && i_out_ready) begin
                if (expected_chars.size() == 0) begin
                    report_mismatch($sformatf("unexpected character %0d last %0b",
                                              o_char_code, o_last));
                end else begin
                    want = expected_chars.pop_front();
                    if (o_char_code !== want.code) begin
                        report_mismatch($sformatf("char_code %0d, expected %0d",
                                                  o_char_code, want.code));
                    end
                    if (o_last !== want.last) begin
                        report_mismatch($sformatf("last %0b, expected %0b on char %0d",
                                                  o_last, want.last, want.code));
                    end
                end
            end
        end
    end

    initial begin
        i_rst_n     = 1'b0;
        i_in_valid  = 1'b0;
        i_value     = '0;
        i_out_ready = 1'b0;
        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        for (int phase = 0; phase < 3; phase++) begin
            case (phase)
                0: begin
                    send_idle_pct = 26;
                    out_stall_pct = 64;
                end
                1: begin
                    send_idle_pct = 64;
                    out_stall_pct = 26;
                end
                default: begin
                    send_idle_pct = 0;
                    out_stall_pct = 0;
                end
            endcase
            if (phase == 0) begin
                for (int row = 0; row < DIRECTED_N; row++) begin
                    send_value(directed_value[row], directed_text[row]);
                end
            end else begin
                drain_text(DRAIN_LIMIT);
            end
            for (int n = 0; n < RANDOM_PER_PHASE; n++) begin
                send_value(random_value(), "");
            end
        end

        drain_text(DRAIN_LIMIT);
        if (expected_chars.size() != 0) begin
            report_mismatch($sformatf("%0d characters never arrived", expected_chars.size()));
        end
        repeat (60) @(negedge i_clk);

        if (mismatch_count == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

    initial begin
        #5_000_000;
        $display("Some tests failed");
        $finish;
    end

endmodule
